### hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion helpers for the RTL. Empty when SYNTH is set.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

### hw/rtl/lmts_pkg.sv
// ============================================================================
// lmts_pkg
// Types and timing constants shared by the LCD mode timing sequencer.
// ============================================================================
`default_nettype none

package lmts_pkg;

    // Phase lengths in cycles
    localparam int unsigned SEARCH_CYCLES   = 80;
    localparam int unsigned TRANSFER_CYCLES = 172;
    localparam int unsigned HBLANK_CYCLES   = 204;
    localparam int unsigned LINE_CYCLES     = SEARCH_CYCLES + TRANSFER_CYCLES + HBLANK_CYCLES;

    // Line numbers
    localparam int unsigned VISIBLE_LINES = 144;
    localparam int unsigned LAST_LINE_END = 154;

    // Field widths
    localparam int unsigned ELAPSED_W = 8;
    localparam int unsigned LINE_W    = 8;
    localparam int unsigned CNT_W     = 10;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 8;

    // Display modes
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COMPARE_LINE   = 2'd0,
        CFG_HBLANK_REQ_EN  = 2'd1,
        CFG_MATCH_REQ_EN   = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

    // Configuration registers as seen by the sequencer
    typedef struct packed {
        logic [LINE_W-1:0] compare_line;
        logic              hblank_req_en;
        logic              match_req_en;
    } t_cfg;

    // One result of a time step
    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              line_end;
        logic              frame_done;
        logic              vblank_req;
        logic              status_req;
        logic              line_match;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/lcd_mode_timing_sequencer.sv
// LCD mode timing sequencer. Each input transfer carries the cycles elapsed
// since the last step; the block adds them to its cycle counter, makes at most
// one mode change (object search, pixel transfer, horizontal blank, vertical
// blank) and returns one result per input. Throughput is one item per clock
// while the result is not stalled: the step is a single add, compare and
// constant remainder between the input register and the result register,
// and the sequencer state updates in that same cycle, so back-to-back items
// see each other's state. A stalled result holds while the input register
// keeps taking one more item. Configuration writes are always ready and
// take effect on the next step.
// ============================================================================
// lcd_mode_timing_sequencer
// Top level: input register, timing core, config registers, result register.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module lcd_mode_timing_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [lmts_pkg::ELAPSED_W-1:0]  i_elapsed_cycles,
    // Output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_mode,
    output logic [lmts_pkg::LINE_W-1:0]          o_line,
    output logic                                 o_line_end,
    output logic                                 o_frame_done,
    output logic                                 o_vblank_request,
    output logic                                 o_status_request,
    output logic                                 o_line_match,
    // Configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [lmts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [lmts_pkg::CFG_DAT_W-1:0]  i_cfg_data
);
    import lmts_pkg::*;

    logic                 r_s1_valid;
    logic [ELAPSED_W-1:0] r_s1_elapsed;
    logic                 r_out_valid;
    t_result              r_out;

    logic    out_adv;
    logic    s1_adv;
    logic    step;
    t_cfg    cfg;
    t_result step_result;

    // Handshake: result register frees when empty or taken
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_adv;
    assign step       = r_s1_valid && out_adv;
    assign o_in_stall = !s1_adv;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    lmts_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Sequencer state and step logic
    lmts_timing_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_elapsed (r_s1_elapsed),
        .i_cfg     (cfg),
        .o_result  (step_result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_in_valid;
        end
        if (s1_adv && i_in_valid) begin
            r_s1_elapsed <= i_elapsed_cycles;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_mode           = r_out.mode;
    assign o_line           = r_out.line;
    assign o_line_end       = r_out.line_end;
    assign o_frame_done     = r_out.frame_done;
    assign o_vblank_request = r_out.vblank_req;
    assign o_status_request = r_out.status_req;
    assign o_line_match     = r_out.line_match;

    // Vertical blank entry lands on line 144 in vblank mode
    `ASSERT_IMPLIES(a_vblank_entry, i_clk, i_rst_n, r_out_valid && r_out.vblank_req,
        r_out.mode == MODE_VBLANK && r_out.line == LINE_W'(VISIBLE_LINES))
    // Status request only on entry to horizontal blank
    `ASSERT_IMPLIES(a_status_mode, i_clk, i_rst_n, r_out_valid && r_out.status_req,
        r_out.mode == MODE_HBLANK)
    // Line end leads to object search or vertical blank
    `ASSERT_IMPLIES(a_line_end_mode, i_clk, i_rst_n, r_out_valid && r_out.line_end,
        r_out.mode == MODE_SEARCH || r_out.mode == MODE_VBLANK)

endmodule

`default_nettype wire

### hw/rtl/lmts_cfg_regs.sv
// ============================================================================
// lmts_cfg_regs
// Configuration register file: compare line and status request enables.
// ============================================================================
`default_nettype none

module lmts_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_wr_en,
    input  wire logic [lmts_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [lmts_pkg::CFG_DAT_W-1:0]  i_wr_data,
    output lmts_pkg::t_cfg                       o_cfg
);
    import lmts_pkg::*;

    t_cfg r_cfg;

    // Register writes; unused index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_COMPARE_LINE:  r_cfg.compare_line  <= i_wr_data[LINE_W-1:0];
                CFG_HBLANK_REQ_EN: r_cfg.hblank_req_en <= i_wr_data[0];
                CFG_MATCH_REQ_EN:  r_cfg.match_req_en  <= i_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### hw/rtl/lmts_timing_core.sv
// ============================================================================
// lmts_timing_core
// Mode, line and cycle counter state with the combinational step logic.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module lmts_timing_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_step,
    input  wire logic [lmts_pkg::ELAPSED_W-1:0]  i_elapsed,
    input  wire lmts_pkg::t_cfg                  i_cfg,
    output lmts_pkg::t_result                    o_result
);
    import lmts_pkg::*;

    localparam logic [CNT_W-1:0]  C_SEARCH    = CNT_W'(SEARCH_CYCLES);
    localparam logic [CNT_W-1:0]  C_TRANSFER  = CNT_W'(TRANSFER_CYCLES);
    localparam logic [CNT_W-1:0]  C_TRANSFER2 = CNT_W'(2 * TRANSFER_CYCLES);
    localparam logic [CNT_W-1:0]  C_HBLANK    = CNT_W'(HBLANK_CYCLES);
    localparam logic [CNT_W-1:0]  C_HBLANK2   = CNT_W'(2 * HBLANK_CYCLES);
    localparam logic [CNT_W-1:0]  C_LINE      = CNT_W'(LINE_CYCLES);
    localparam logic [LINE_W-1:0] C_VISIBLE   = LINE_W'(VISIBLE_LINES);
    localparam logic [LINE_W-1:0] C_LAST      = LINE_W'(LAST_LINE_END);

    // Remainder by 80 = 16 * 5: low nibble kept, upper bits reduced mod 5
    // with a multiply by 13/64 (exact for values below 64).
    function automatic logic [CNT_W-1:0] mod_search(input logic [CNT_W-1:0] x);
        logic [5:0] hi;
        logic [9:0] prod;
        logic [3:0] q;
        logic [5:0] r;
        hi   = x[CNT_W-1:4];
        prod = 10'(hi) * 10'd13;
        q    = prod[9:6];
        r    = hi - (6'(q) * 6'd5);
        return {r, x[3:0]};
    endfunction

    t_mode             r_mode;
    logic [LINE_W-1:0] r_line;
    logic [CNT_W-1:0]  r_cnt;

    t_mode             n_mode;
    logic [LINE_W-1:0] n_line;
    logic [CNT_W-1:0]  n_cnt;
    logic [CNT_W-1:0]  sum;
    logic [LINE_W-1:0] line_inc;
    logic              line_end;
    logic              frame_done;
    logic              vblank_req;
    logic              status_req;

    assign sum      = r_cnt + CNT_W'(i_elapsed);
    assign line_inc = r_line + LINE_W'(1);

    // Step: add elapsed cycles, at most one mode change
    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_cnt      = sum;
        line_end   = 1'b0;
        frame_done = 1'b0;
        vblank_req = 1'b0;
        status_req = 1'b0;
        unique case (r_mode)
            MODE_HBLANK: begin
                if (sum >= C_HBLANK) begin
                    n_cnt    = (sum >= C_HBLANK2) ? sum - C_HBLANK2 : sum - C_HBLANK;
                    n_line   = line_inc;
                    line_end = 1'b1;
                    if (line_inc >= C_VISIBLE) begin
                        n_mode     = MODE_VBLANK;
                        vblank_req = 1'b1;
                    end else begin
                        n_mode = MODE_SEARCH;
                    end
                end
            end
            MODE_VBLANK: begin
                if (sum >= C_LINE) begin
                    n_cnt  = sum - C_LINE;
                    n_line = line_inc;
                    if (line_inc >= C_LAST) begin
                        n_line     = '0;
                        frame_done = 1'b1;
                        n_mode     = MODE_SEARCH;
                    end
                end
            end
            MODE_SEARCH: begin
                if (sum >= C_SEARCH) begin
                    n_cnt  = mod_search(sum);
                    n_mode = MODE_TRANSFER;
                end
            end
            MODE_TRANSFER: begin
                if (sum >= C_TRANSFER) begin
                    // sum stays below three transfer lengths
                    n_cnt      = (sum >= C_TRANSFER2) ? sum - C_TRANSFER2
                                                      : sum - C_TRANSFER;
                    n_mode     = MODE_HBLANK;
                    status_req = i_cfg.hblank_req_en |
                                 (i_cfg.match_req_en & (r_line == i_cfg.compare_line));
                end
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SEARCH;
            r_line <= '0;
            r_cnt  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_cnt  <= n_cnt;
        end
    end

    assign o_result = '{
        mode:       n_mode,
        line:       n_line,
        line_end:   line_end,
        frame_done: frame_done,
        vblank_req: vblank_req,
        status_req: status_req,
        line_match: (n_line == i_cfg.compare_line)
    };

    // Counter never holds a full line or more
    `ASSERT_IMPLIES(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt < C_LINE)
    // Frame end restarts at line 0 in object search
    `ASSERT_NEXT(a_frame_wrap, i_clk, i_rst_n, i_step && frame_done,
        r_line == '0 && r_mode == MODE_SEARCH)
    // Vertical blank only on lines 144 to 153
    `ASSERT_IMPLIES(a_vblank_lines, i_clk, i_rst_n, r_mode == MODE_VBLANK,
        r_line >= C_VISIBLE && r_line < C_LAST)

endmodule

`default_nettype wire

### tb/sv/lcd_mode_timing_sequencer_test.sv
`timescale 1ns / 1ps
// ============================================================================
// lcd_mode_timing_sequencer_test
// Self-checking bench for the LCD mode timing sequencer. A directed table
// walks the first phase changes out of reset, then random elapsed-cycle
// steps run under several register settings and idle/stall patterns. Every
// result transfer is checked field by field against a cycle-count predictor.
// ============================================================================

module lcd_mode_timing_sequencer_test;

    import lmts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle;

    // One offered step: elapsed cycles, and a typed-in result where known
    typedef struct packed {
        logic [ELAPSED_W-1:0] elapsed;
        logic                 typed;
        t_result              want;
    } t_step_row;

    // Directed steps from reset (all registers at reset value).
    // Result order: mode, line, line_end, frame_done, vblank, status, match.
    localparam t_step_row DIRECTED_ROWS [0:20] = '{
        '{8'd0,   1'b1, '{MODE_SEARCH,   8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'd255, 1'b1, '{MODE_TRANSFER, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'd255, 1'b1, '{MODE_HBLANK,   8'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
        '{8'd255, 1'b1, '{MODE_SEARCH,   8'd1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd1,   1'b0, '0},
        '{8'd254, 1'b0, '0},
        '{8'd128, 1'b0, '0},
        '{8'd127, 1'b0, '0},
        '{8'd80,  1'b0, '0},
        '{8'd172, 1'b0, '0},
        '{8'd204, 1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd255, 1'b0, '0},
        '{8'd0,   1'b0, '0},
        '{8'd85,  1'b0, '0},
        '{8'd170, 1'b0, '0},
        '{8'd15,  1'b0, '0},
        '{8'd240, 1'b0, '0}
    };

    // DUT connections
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_stall;
    logic [ELAPSED_W-1:0]  i_elapsed_cycles = '0;
    logic                  o_out_valid;
    logic                  i_out_stall      = 1'b0;
    logic [1:0]            o_mode;
    logic [LINE_W-1:0]     o_line;
    logic                  o_line_end;
    logic                  o_frame_done;
    logic                  o_vblank_request;
    logic                  o_status_request;
    logic                  o_line_match;
    logic                  i_cfg_valid      = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index      = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data       = '0;

    // Bench state
    t_step_row         pending_steps[$];
    t_result           expected_results[$];
    int                errors = 0;
    int                cycles = 0;
    t_idle             idle_mode = IDLE_NONE;
    int                hold_left = 0;
    int                pressure_requests = 0;
    int                pressure_served = 0;

    // Predicted sequencer state and register copies
    t_mode             seq_mode  = MODE_SEARCH;
    logic [LINE_W-1:0] seq_line  = '0;
    logic [CNT_W-1:0]  seq_count = '0;
    logic [LINE_W-1:0] cfg_compare  = '0;
    logic              cfg_hblank_en = 1'b0;
    logic              cfg_match_en  = 1'b0;

    lcd_mode_timing_sequencer uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_elapsed_cycles (i_elapsed_cycles),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_mode           (o_mode),
        .o_line           (o_line),
        .o_line_end       (o_line_end),
        .o_frame_done     (o_frame_done),
        .o_vblank_request (o_vblank_request),
        .o_status_request (o_status_request),
        .o_line_match     (o_line_match),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Clock
    always #2 i_clk = ~i_clk;

    // Cycle-count watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Advance the predicted counter by one step; at most one mode change
    task automatic advance_timing(input logic [ELAPSED_W-1:0] elapsed, output t_result res);
        int unsigned       cnt;
        logic [LINE_W-1:0] ln;
        t_mode             md;
        cnt = seq_count + elapsed;
        ln  = seq_line;
        md  = seq_mode;
        res = '0;
        case (md)
            MODE_HBLANK: begin
                if (cnt >= HBLANK_CYCLES) begin
                    cnt = cnt % HBLANK_CYCLES;
                    ln = ln + 8'd1;
                    res.line_end = 1'b1;
                    // visible lines used up: enter vblank
                    if (ln >= VISIBLE_LINES) begin
                        md = MODE_VBLANK;
                        res.vblank_req = 1'b1;
                    end else begin
                        md = MODE_SEARCH;
                    end
                end
            end
            MODE_VBLANK: begin
                if (cnt >= LINE_CYCLES) begin
                    cnt = cnt % LINE_CYCLES;
                    ln = ln + 8'd1;
                    if (ln >= LAST_LINE_END) begin
                        ln = '0;
                        res.frame_done = 1'b1;
                        md = MODE_SEARCH;
                    end
                end
            end
            MODE_SEARCH: begin
                if (cnt >= SEARCH_CYCLES) begin
                    cnt = cnt % SEARCH_CYCLES;
                    md = MODE_TRANSFER;
                end
            end
            default: begin
                if (cnt >= TRANSFER_CYCLES) begin
                    cnt = cnt % TRANSFER_CYCLES;
                    md = MODE_HBLANK;
                    // match is tested against the line still in progress
                    if (cfg_hblank_en || (cfg_match_en && ln == cfg_compare))
                        res.status_req = 1'b1;
                end
            end
        endcase
        seq_count = cnt[CNT_W-1:0];
        seq_line  = ln;
        seq_mode  = md;
        res.mode       = md;
        res.line       = ln;
        res.line_match = (ln == cfg_compare);
    endtask

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return ELAPSED_W'($urandom_range(1, 8));
            2, 3:    return '1;
            default: return ELAPSED_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 59;
            IDLE_BOTH:   return $urandom_range(0, 99) < 12;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 59;
            IDLE_BOTH:     return $urandom_range(0, 99) < 12;
            default:       return 1'b0;
        endcase
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Register copies follow accepted config transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_compare   <= '0;
            cfg_hblank_en <= 1'b0;
            cfg_match_en  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COMPARE_LINE:  cfg_compare   <= i_cfg_data;
                CFG_HBLANK_REQ_EN: cfg_hblank_en <= i_cfg_data[0];
                CFG_MATCH_REQ_EN:  cfg_match_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Predict on every input transfer
    always @(posedge i_clk) begin : step_monitor
        t_step_row row;
        t_result   res;
        if (!i_rst_n) begin
            seq_mode  = MODE_SEARCH;
            seq_line  = '0;
            seq_count = '0;
        end else if (i_in_valid && !o_in_stall) begin
            row = pending_steps.pop_front();
            advance_timing(i_elapsed_cycles, res);
            expected_results.push_back(row.typed ? row.want : res);
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (pressure_served != pressure_requests) begin
            hold_left       <= HOLD_CYCLES;
            pressure_served <= pressure_requests;
        end
    end

    // Result checker and receiver stall
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result transfer with no expectation waiting");
                errors++;
            end else begin
                want = expected_results.pop_front();
                check_field("mode",           want.mode,       o_mode);
                check_field("line",           want.line,       o_line);
                check_field("line_end",       want.line_end,   o_line_end);
                check_field("frame_done",     want.frame_done, o_frame_done);
                check_field("vblank_request", want.vblank_req, o_vblank_request);
                check_field("status_request", want.status_req, o_status_request);
                check_field("line_match",     want.line_match, o_line_match);
            end
        end
        i_out_stall <= (hold_left != 0) || receiver_stalls();
    end

    // Offer one step; returns at the edge it transfers
    task automatic send_item(input logic [ELAPSED_W-1:0] elapsed, input logic typed,
                             input t_result want);
        t_step_row row;
        while (sender_idles()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        row.elapsed = elapsed;
        row.typed   = typed;
        row.want    = want;
        pending_steps.push_back(row);
        i_in_valid       <= 1'b1;
        i_elapsed_cycles <= elapsed;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stop offering and wait for every expected result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_steps.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Valid stays high across back-to-back writes; caller lowers it
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Upper data bits are random on the 1-bit registers
    task automatic set_config(input logic [LINE_W-1:0] compare, input logic hb_en,
                              input logic mt_en);
        write_reg(CFG_COMPARE_LINE, compare);
        write_reg(CFG_HBLANK_REQ_EN, {(CFG_DAT_W-1)'($urandom_range(0, 127)), hb_en});
        write_reg(CFG_MATCH_REQ_EN, {(CFG_DAT_W-1)'($urandom_range(0, 127)), mt_en});
        // unused index must be ignored
        write_reg(CFG_UNUSED, CFG_DAT_W'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input t_idle mode, input int count, input bit squeeze);
        idle_mode <= mode;
        for (int n = 0; n < count; n++) begin
            if (squeeze && n == 16)
                pressure_requests <= pressure_requests + 1;
            send_item(random_elapsed(), 1'b0, '0);
        end
        drain();
    endtask

    // Main sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, registers at reset values
        foreach (DIRECTED_ROWS[k])
            send_item(DIRECTED_ROWS[k].elapsed, DIRECTED_ROWS[k].typed,
                      DIRECTED_ROWS[k].want);
        drain();

        set_config(8'd255, 1'b1, 1'b0);
        run_phase(IDLE_NONE, 150, 1'b0);

        set_config(LINE_W'($urandom_range(0, 143)), 1'b0, 1'b1);
        run_phase(IDLE_SENDER, 200, 1'b0);

        set_config(8'd143, 1'b1, 1'b1);
        run_phase(IDLE_RECEIVER, 200, 1'b0);

        set_config(8'd0, 1'b0, 1'b1);
        run_phase(IDLE_BOTH, 200, 1'b0);

        // compare beyond the last line never matches; receiver holds off
        set_config(8'd154, 1'b0, 1'b0);
        run_phase(IDLE_NONE, 200, 1'b1);

        set_config(8'd153, 1'($urandom_range(0, 1)), 1'b1);
        run_phase(IDLE_BOTH, 180, 1'b0);

        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/lmts_pkg.sv
hw/rtl/lmts_cfg_regs.sv
hw/rtl/lmts_timing_core.sv
hw/rtl/lcd_mode_timing_sequencer.sv
tb/sv/lcd_mode_timing_sequencer_test.sv
